@@ hw/rtl/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared widths, codes and types of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

	localparam int ADDR_W   = 32;
	localparam int CNT_W    = 11;
	localparam int UNITS_W  = 13;
	localparam int STATUS_W = 4;
	localparam int CFG_IDX_W = 2;

	localparam int DEF_MAX_BLOCKS  = 1024;
	localparam int DEF_ALIGN_BYTES = 8;
	localparam int RESET_BLOCK_COUNT = 1024;

	localparam logic OCC_EMPTY    = 1'b0;
	localparam logic OCC_OCCUPIED = 1'b1;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_UNITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK           = 4'd0;
	localparam logic [STATUS_W-1:0] STAT_NO_SPACE     = 4'd1;
	localparam logic [STATUS_W-1:0] STAT_STACK_EMPTY  = 4'd2;
	localparam logic [STATUS_W-1:0] STAT_SLOT_BUSY    = 4'd3;
	localparam logic [STATUS_W-1:0] STAT_POOL_EMPTY   = 4'd4;
	localparam logic [STATUS_W-1:0] STAT_BELOW        = 4'd5;
	localparam logic [STATUS_W-1:0] STAT_BEYOND       = 4'd6;
	localparam logic [STATUS_W-1:0] STAT_MISALIGNED   = 4'd7;
	localparam logic [STATUS_W-1:0] STAT_ALREADY_FREE = 4'd8;
	localparam logic [STATUS_W-1:0] STAT_STACK_FULL   = 4'd9;

	typedef struct packed {
		logic             done;
		logic             exact;
		logic [CNT_W-1:0] quotient;
	} div_res_t;

endpackage

@@ hw/rtl/fbpa_ram.sv @@
// ----------------------------------------------------------------------------
// fbpa_ram
// Simple dual-port synchronous memory with a registered read port.
// ----------------------------------------------------------------------------
module fbpa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/fbpa_divider.sv @@
// ----------------------------------------------------------------------------
// fbpa_divider
// Restoring divider, one quotient bit per cycle, for a dividend known to give
// a quotient that fits in the count width. Reports quotient and exactness.
// ----------------------------------------------------------------------------
module fbpa_divider #(
	parameter int DIVISOR_W = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	input  logic [DIVISOR_W+fbpa_pkg::CNT_W-1:0]      dividend,
	input  logic [DIVISOR_W-1:0]                      divisor,
	output fbpa_pkg::div_res_t                        res
);
	import fbpa_pkg::*;

	localparam int QW    = CNT_W;
	localparam int STEPW = $clog2(QW + 1);

	logic [DIVISOR_W-1:0] rem_q;
	logic [QW-1:0]        quo_q;
	logic [STEPW-1:0]     step_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIVISOR_W:0]   trial;
	logic                 ge;
	logic [DIVISOR_W:0]   diff;

	always_comb begin
		trial = {rem_q, quo_q[QW-1]};
		diff  = trial - {1'b0, divisor};
		ge    = (trial >= {1'b0, divisor});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEPW'(QW);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEPW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DIVISOR_W+QW-1:QW];
			quo_q <= dividend[QW-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign res.done     = done_q;
	assign res.exact    = (rem_q == '0);
	assign res.quotient = quo_q;

endmodule

@@ hw/rtl/fixed_block_pool_allocator_core.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// Fixed-size block pool allocator with an occupancy memory and a stack of
// freed slot indices, both held in synchronous memories.
//
//   Channel  Direction  Handshake            Payload
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//   in       in         in_valid/in_stall    cmd, block_address
//   out      out        out_valid/out_stall  granted_address, status_code,
//                                            free_blocks
//
// One item is in work at a time. An allocate steps through ARD, ACHK, AMUL and
// AADD, after POP when it takes a slot off the stack; a free steps through
// FLIM, FCHK, FDIV (the 11-step divider turns the offset into a slot index),
// FRD and FCHK2. Errors finish early. After reset and each block_count write,
// a clearing pass sweeps the occupancy memory while in_stall stays high.
// A new item is taken while a result still waits on a stalled output.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_core #(
	parameter int MAX_BLOCKS  = fbpa_pkg::DEF_MAX_BLOCKS,
	parameter int ALIGN_BYTES = fbpa_pkg::DEF_ALIGN_BYTES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbpa_pkg::ADDR_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            cmd,
	input  logic [fbpa_pkg::ADDR_W-1:0]     block_address,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [fbpa_pkg::ADDR_W-1:0]     granted_address,
	output logic [fbpa_pkg::STATUS_W-1:0]   status_code,
	output logic [fbpa_pkg::CNT_W-1:0]      free_blocks
);
	import fbpa_pkg::*;

	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int SIZE_W = UNITS_W + $clog2(ALIGN_BYTES + 1);
	localparam int LIM_W  = CNT_W + SIZE_W;
	localparam int CAP_RESET_I = (RESET_BLOCK_COUNT > MAX_BLOCKS) ? MAX_BLOCKS
		: RESET_BLOCK_COUNT;
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(CAP_RESET_I);
	localparam logic [IDX_W-1:0] CLR_LAST  = IDX_W'(MAX_BLOCKS - 1);

	typedef enum logic [12:0] {
		S_CLEAR = 13'b0000000000001,
		S_IDLE  = 13'b0000000000010,
		S_POP   = 13'b0000000000100,
		S_ARD   = 13'b0000000001000,
		S_ACHK  = 13'b0000000010000,
		S_AMUL  = 13'b0000000100000,
		S_AADD  = 13'b0000001000000,
		S_FLIM  = 13'b0000010000000,
		S_FCHK  = 13'b0000100000000,
		S_FDIV  = 13'b0001000000000,
		S_FRD   = 13'b0010000000000,
		S_FCHK2 = 13'b0100000000000,
		S_DONE  = 13'b1000000000000
	} state_t;

	state_t               state_q;
	logic [IDX_W-1:0]     clr_q;
	logic [CNT_W-1:0]     cap_q;
	logic [SIZE_W-1:0]    size_q;
	logic [ADDR_W-1:0]    base_q;
	logic [CNT_W-1:0]     fresh_q;
	logic [CNT_W-1:0]     fill_q;
	logic [CNT_W-1:0]     free_total_q;
	logic                 out_valid_q;

	logic [IDX_W-1:0]     slot_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [ADDR_W:0]      off_q;
	logic [LIM_W-1:0]     limit_q;
	logic [IDX_W+SIZE_W-1:0] prod_q;
	logic [ADDR_W-1:0]    res_addr_q;
	logic [STATUS_W-1:0]  res_status_q;
	logic [ADDR_W-1:0]    out_addr_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [CNT_W-1:0]     out_free_q;

	logic                 in_accept;
	logic                 cfg_write;
	logic                 out_load;
	logic [CNT_W-1:0]     new_cap;
	logic [UNITS_W-1:0]   new_units;
	logic                 occ_we;
	logic [IDX_W-1:0]     occ_waddr;
	logic                 occ_wdata;
	logic                 occ_rdata;
	logic                 stk_we;
	logic [IDX_W-1:0]     stk_raddr;
	logic [IDX_W-1:0]     stk_rdata;
	logic                 free_ok;
	logic                 div_start;
	div_res_t             div_res;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		if (32'(cfg_data[CNT_W-1:0]) > 32'(MAX_BLOCKS)) begin
			new_cap = CNT_W'(MAX_BLOCKS);
		end else begin
			new_cap = cfg_data[CNT_W-1:0];
		end
		new_units = (cfg_data[UNITS_W-1:0] == '0) ? UNITS_W'(1) : cfg_data[UNITS_W-1:0];
	end

	assign stk_raddr = IDX_W'(fill_q - 1'b1);
	assign free_ok   = (occ_rdata == OCC_OCCUPIED) && (fill_q < cap_q);
	assign stk_we    = (state_q == S_FCHK2) && free_ok;
	assign div_start = (state_q == S_FCHK) && (free_total_q != cap_q) && !off_q[ADDR_W]
		&& (off_q[ADDR_W-1:0] < ADDR_W'(limit_q));

	always_comb begin
		occ_we    = 1'b0;
		occ_waddr = slot_q;
		occ_wdata = OCC_EMPTY;
		case (state_q)
			S_CLEAR: begin
				occ_we    = 1'b1;
				occ_waddr = clr_q;
			end
			S_ACHK: begin
				occ_we    = (occ_rdata == OCC_EMPTY);
				occ_wdata = OCC_OCCUPIED;
			end
			S_FCHK2: begin
				occ_we = free_ok;
			end
			default: begin
				occ_we = 1'b0;
			end
		endcase
	end

	fbpa_ram #(
		.WIDTH (1),
		.DEPTH (MAX_BLOCKS)
	) u_occ_ram (
		.clk   (clk),
		.we    (occ_we),
		.waddr (occ_waddr),
		.wdata (occ_wdata),
		.raddr (slot_q),
		.rdata (occ_rdata)
	);

	fbpa_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_BLOCKS)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (IDX_W'(fill_q)),
		.wdata (slot_q),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	fbpa_divider #(
		.DIVISOR_W (SIZE_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (off_q[LIM_W-1:0]),
		.divisor  (size_q),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			cap_q        <= CAP_RESET;
			size_q       <= SIZE_W'(ALIGN_BYTES);
			base_q       <= '0;
			fresh_q      <= '0;
			fill_q       <= '0;
			free_total_q <= CAP_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write && (cfg_index == REG_BLOCK_COUNT)) begin
				cap_q        <= new_cap;
				free_total_q <= new_cap;
				fresh_q      <= '0;
				fill_q       <= '0;
				clr_q        <= '0;
				state_q      <= S_CLEAR;
			end else begin
				case (state_q)
					S_CLEAR: begin
						clr_q <= clr_q + 1'b1;
						if (clr_q == CLR_LAST) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (in_accept) begin
							if (cmd == CMD_ALLOC) begin
								if (free_total_q == '0) begin
									state_q <= S_DONE;
								end else if (fresh_q < cap_q) begin
									fresh_q <= fresh_q + 1'b1;
									state_q <= S_ARD;
								end else if (fill_q == '0) begin
									state_q <= S_DONE;
								end else begin
									fill_q  <= fill_q - 1'b1;
									state_q <= S_POP;
								end
							end else begin
								state_q <= S_FLIM;
							end
						end
					end
					S_POP:  state_q <= S_ARD;
					S_ARD:  state_q <= S_ACHK;
					S_ACHK: begin
						if (occ_rdata == OCC_EMPTY) begin
							free_total_q <= free_total_q - 1'b1;
							state_q      <= S_AMUL;
						end else begin
							state_q <= S_DONE;
						end
					end
					S_AMUL: state_q <= S_AADD;
					S_AADD: state_q <= S_DONE;
					S_FLIM: state_q <= S_FCHK;
					S_FCHK: state_q <= div_start ? S_FDIV : S_DONE;
					S_FDIV: begin
						if (div_res.done) begin
							state_q <= div_res.exact ? S_FRD : S_DONE;
						end
					end
					S_FRD:  state_q <= S_FCHK2;
					S_FCHK2: begin
						if (free_ok) begin
							free_total_q <= free_total_q + 1'b1;
							fill_q       <= fill_q + 1'b1;
						end
						state_q <= S_DONE;
					end
					S_DONE: begin
						if (out_load) begin
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_CLEAR;
				endcase
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_BLOCK_UNITS: size_q <= SIZE_W'(new_units) * SIZE_W'(ALIGN_BYTES);
					REG_REGION_BASE: base_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					res_addr_q <= '0;
					addr_q     <= block_address;
					slot_q     <= IDX_W'(fresh_q);
					if (free_total_q == '0) begin
						res_status_q <= STAT_NO_SPACE;
					end else if (fresh_q < cap_q) begin
						res_status_q <= STAT_OK;
					end else if (fill_q == '0) begin
						res_status_q <= STAT_STACK_EMPTY;
					end else begin
						res_status_q <= STAT_OK;
					end
				end
			end
			S_POP: slot_q <= stk_rdata;
			S_ACHK: begin
				if (occ_rdata != OCC_EMPTY) begin
					res_status_q <= STAT_SLOT_BUSY;
				end
			end
			S_AMUL: prod_q <= slot_q * size_q;
			S_AADD: res_addr_q <= base_q + ADDR_W'(prod_q);
			S_FLIM: begin
				limit_q <= cap_q * size_q;
				off_q   <= {1'b0, addr_q} - {1'b0, base_q};
			end
			S_FCHK: begin
				if (free_total_q == cap_q) begin
					res_status_q <= STAT_POOL_EMPTY;
				end else if (off_q[ADDR_W]) begin
					res_status_q <= STAT_BELOW;
				end else if (off_q[ADDR_W-1:0] >= ADDR_W'(limit_q)) begin
					res_status_q <= STAT_BEYOND;
				end else begin
					res_status_q <= STAT_OK;
				end
			end
			S_FDIV: begin
				if (div_res.done) begin
					slot_q <= IDX_W'(div_res.quotient);
					if (!div_res.exact) begin
						res_status_q <= STAT_MISALIGNED;
					end
				end
			end
			S_FCHK2: begin
				if (occ_rdata == OCC_EMPTY) begin
					res_status_q <= STAT_ALREADY_FREE;
				end else if (fill_q >= cap_q) begin
					res_status_q <= STAT_STACK_FULL;
				end
			end
			S_DONE: begin
				if (out_load) begin
					out_addr_q   <= res_addr_q;
					out_status_q <= res_status_q;
					out_free_q   <= free_total_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign granted_address = out_addr_q;
	assign status_code     = out_status_q;
	assign free_blocks     = out_free_q;

	// Between items, every slot is free, handed out, or waiting on the stack.
	a_free_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |->
		((12'(free_total_q) + 12'(fresh_q)) == (12'(cap_q) + 12'(fill_q))))
		else $error("free count out of balance with fresh counter and stack fill");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q <= cap_q) && (fresh_q <= cap_q))
		else $error("stack fill or fresh counter beyond pool capacity");

	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status_code != STAT_OK) |-> (granted_address == '0))
		else $error("address granted on a failed item");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == S_FDIV))
		else $error("divider finished outside the free sequence");

endmodule
